// ===== hdl/roa_pkg.sv =====
// ----------------------------------------------------------------------------
// roa_pkg
// Shared types and constants for the rectangle occupancy allocator: request
// modes, controller states, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package roa_pkg;

  localparam int MAX_WIDTH_DEF  = 16;
  localparam int MAX_HEIGHT_DEF = 16;

  localparam int MODE_W = 3;
  localparam int POS_W  = 8;
  localparam int DIM_W  = 5;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIND  = 3'd0,
    MODE_PUT   = 3'd1,
    MODE_FREE  = 3'd2,
    MODE_TEST  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  // register select, taken from paddr[2]
  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_BOUNDS,
    S_FPOS,
    S_RD,
    S_CHK,
    S_WR,
    S_CLR
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pos_next;
    logic cell_start;
    logic cell_next;
    logic mem_rd;
    logic mem_wr;
    logic clr_start;
    logic clr_wr;
    logic finish;
    logic ok;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  div_more;
    logic  row_in;
    logic  bounds_ok;
    logic  find_fits;
    logic  p_end;
    logic  h_zero;
    logic  idx_in;
    logic  last_cell;
    logic  rd_bit;
    logic  clr_last;
  } sts_t;

endpackage

// ===== hdl/roa_ctrl.sv =====
// ----------------------------------------------------------------------------
// roa_ctrl
// Sequencer for the allocator: steps the datapath through the position
// decomposition, bounds check, cell scan, cell writes and clearing sweeps.
// ----------------------------------------------------------------------------
module roa_ctrl
  import roa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.mode)
          MODE_FIND: begin
            state_nxt = sts.find_fits ? S_FPOS : S_IDLE;
          end
          MODE_PUT, MODE_TEST, MODE_FREE: begin
            state_nxt = S_DIV;
          end
          MODE_CLEAR: begin
            state_nxt = S_CLR;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (!sts.div_more) state_nxt = S_BOUNDS;
      end
      S_BOUNDS: begin
        if (sts.mode == MODE_FREE) begin
          state_nxt = (sts.row_in && !sts.h_zero) ? S_WR : S_IDLE;
        end else begin
          state_nxt = (sts.bounds_ok && !sts.h_zero) ? S_RD : S_IDLE;
        end
      end
      S_FPOS: begin
        if (sts.p_end) begin
          state_nxt = S_IDLE;
        end else if (sts.bounds_ok) begin
          state_nxt = sts.h_zero ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        if (sts.idx_in) begin
          state_nxt = S_CHK;
        end else if (sts.last_cell) begin
          state_nxt = (sts.mode == MODE_PUT) ? S_WR : S_IDLE;
        end
      end
      S_CHK: begin
        if (sts.rd_bit) begin
          state_nxt = (sts.mode == MODE_FIND) ? S_FPOS : S_IDLE;
        end else if (sts.last_cell) begin
          state_nxt = (sts.mode == MODE_PUT) ? S_WR : S_IDLE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        if (sts.last_cell) state_nxt = S_IDLE;
      end
      S_CLR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        cmd.load = start;
      end
      S_DISPATCH: begin
        case (sts.mode)
          MODE_FIND: begin
            cmd.finish = !sts.find_fits;
          end
          MODE_PUT, MODE_TEST, MODE_FREE: begin
            cmd = '0;
          end
          MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = sts.div_more;
      end
      S_BOUNDS: begin
        if (sts.mode == MODE_FREE) begin
          cmd.cell_start = sts.row_in && !sts.h_zero;
          cmd.finish     = !sts.row_in || sts.h_zero;
          cmd.ok         = sts.row_in;
        end else begin
          cmd.cell_start = sts.bounds_ok && !sts.h_zero;
          cmd.finish     = !sts.bounds_ok || sts.h_zero;
          cmd.ok         = sts.bounds_ok;
        end
      end
      S_FPOS: begin
        if (sts.p_end) begin
          cmd.finish = 1'b1;
        end else if (!sts.bounds_ok) begin
          cmd.pos_next = 1'b1;
        end else if (sts.h_zero) begin
          cmd.finish = 1'b1;
          cmd.ok     = 1'b1;
        end else begin
          cmd.cell_start = 1'b1;
        end
      end
      S_RD: begin
        // cells past the grid end count as free
        if (sts.idx_in) begin
          cmd.mem_rd = 1'b1;
        end else if (!sts.last_cell) begin
          cmd.cell_next = 1'b1;
        end else if (sts.mode == MODE_PUT) begin
          cmd.cell_start = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          cmd.ok     = 1'b1;
        end
      end
      S_CHK: begin
        if (sts.rd_bit) begin
          cmd.pos_next = (sts.mode == MODE_FIND);
          cmd.finish   = (sts.mode != MODE_FIND);
        end else if (!sts.last_cell) begin
          cmd.cell_next = 1'b1;
        end else if (sts.mode == MODE_PUT) begin
          cmd.cell_start = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          cmd.ok     = 1'b1;
        end
      end
      S_WR: begin
        cmd.mem_wr    = 1'b1;
        cmd.cell_next = !sts.last_cell;
        cmd.finish    = sts.last_cell;
        cmd.ok        = sts.last_cell;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.finish = sts.clr_last;
        cmd.ok     = sts.clr_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/roa_dp.sv =====
// ----------------------------------------------------------------------------
// roa_dp
// Allocator datapath: request registers, row/column counters, cell walker,
// the occupancy bitmap (one bit per cell, linear index) and result registers.
// ----------------------------------------------------------------------------
module roa_dp
  import roa_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [DIM_W-1:0]  grid_width,
  input  logic [DIM_W-1:0]  grid_height,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [POS_W-1:0]  in_position,
  input  logic [DIM_W-1:0]  in_item_width,
  input  logic [DIM_W-1:0]  in_item_height,
  output logic [POS_W-1:0]  out_found_position,
  output logic              out_success,
  output logic              out_valid
);

  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int GWW = $clog2(MAX_WIDTH + 1);
  localparam int GHW = $clog2(MAX_HEIGHT + 1);
  localparam int TW  = $clog2(CELL_COUNT + 1);
  // covers free-walk indices running past the grid end
  localparam int IW  = $clog2(CELL_COUNT + 32 * MAX_WIDTH + 288);

  logic [MODE_W-1:0] mode_r;
  logic [DIM_W-1:0]  w_r;
  logic [DIM_W-1:0]  h_r;
  logic [GWW-1:0]    gw_r;
  logic [GHW-1:0]    gh_r;
  logic [TW-1:0]     total_r;
  logic [IW-1:0]     wp_r;
  logic [IW-1:0]     row_r;
  logic [IW-1:0]     col_r;
  logic [IW-1:0]     base_r;
  logic [DIM_W-1:0]  x_r;
  logic [DIM_W-1:0]  y_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              rd_bit_r;
  logic [POS_W-1:0]  found_r;
  logic              success_r;
  logic              valid_r;

  logic              mem [CELL_COUNT];

  logic [GWW-1:0]    gw_c;
  logic [GHW-1:0]    gh_c;
  logic [IW-1:0]     gw_x;
  logic [IW-1:0]     gh_x;
  logic [IW-1:0]     total_x;
  logic [IW-1:0]     idx;
  logic [DIM_W-1:0]  wc_m1;
  logic              idx_in;
  logic              last_x;
  logic              is_find;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic              mem_wd;

  // clamp the grid registers into 1..MAX
  always_comb begin
    if (grid_width == '0) begin
      gw_c = GWW'(1);
    end else if (IW'(grid_width) > IW'(MAX_WIDTH)) begin
      gw_c = GWW'(MAX_WIDTH);
    end else begin
      gw_c = GWW'(grid_width);
    end
    if (grid_height == '0) begin
      gh_c = GHW'(1);
    end else if (IW'(grid_height) > IW'(MAX_HEIGHT)) begin
      gh_c = GHW'(MAX_HEIGHT);
    end else begin
      gh_c = GHW'(grid_height);
    end
  end

  assign is_find = (in_mode == MODE_FIND);
  assign gw_x    = IW'(gw_r);
  assign gh_x    = IW'(gh_r);
  assign total_x = IW'(total_r);
  assign idx     = base_r + IW'(x_r);
  assign idx_in  = (idx < total_x);
  assign wc_m1   = (w_r == '0) ? '0 : w_r - DIM_W'(1);
  assign last_x  = (x_r == wc_m1);

  always_comb begin
    sts.mode      = mode_t'(mode_r);
    sts.div_more  = (col_r >= gw_x);
    sts.row_in    = (row_r < gh_x);
    sts.bounds_ok = (row_r < gh_x) && (row_r + IW'(h_r) <= gh_x) &&
                    (col_r + IW'(w_r) <= gw_x);
    sts.find_fits = (IW'(w_r) <= gw_x) && (IW'(h_r) <= gh_x);
    sts.p_end     = (wp_r >= total_x);
    sts.h_zero    = (h_r == '0);
    sts.idx_in    = idx_in;
    sts.last_cell = last_x && (y_r == h_r - DIM_W'(1));
    sts.rd_bit    = rd_bit_r;
    sts.clr_last  = (clr_cnt_r == AW'(CELL_COUNT - 1));
  end

  // request and walker registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      w_r     <= in_item_width;
      h_r     <= in_item_height;
      gw_r    <= gw_c;
      gh_r    <= gh_c;
      total_r <= TW'(gw_c * gh_c);
      wp_r    <= is_find ? '0 : IW'(in_position);
      col_r   <= is_find ? '0 : IW'(in_position);
      row_r   <= '0;
    end else if (cmd.div_step) begin
      col_r <= col_r - gw_x;
      row_r <= row_r + IW'(1);
    end else if (cmd.pos_next) begin
      wp_r <= wp_r + IW'(1);
      if (col_r + IW'(1) == gw_x) begin
        col_r <= '0;
        row_r <= row_r + IW'(1);
      end else begin
        col_r <= col_r + IW'(1);
      end
    end
    if (cmd.cell_start) begin
      base_r <= wp_r;
      x_r    <= '0;
      y_r    <= '0;
    end else if (cmd.cell_next) begin
      if (last_x) begin
        x_r    <= '0;
        y_r    <= y_r + DIM_W'(1);
        base_r <= base_r + gw_x;
      end else begin
        x_r <= x_r + DIM_W'(1);
      end
    end
  end

  // sweep counter, runs the clearing pass straight out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_start) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign mem_we = cmd.clr_wr || (cmd.mem_wr && idx_in);
  assign mem_wa = cmd.clr_wr ? clr_cnt_r : idx[AW-1:0];
  assign mem_wd = !cmd.clr_wr && (mode_r == MODE_PUT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.mem_rd) begin
      rd_bit_r <= mem[idx[AW-1:0]];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      success_r <= cmd.ok;
      found_r   <= (cmd.ok && mode_r == MODE_FIND) ? wp_r[POS_W-1:0] : '0;
    end
  end

  assign out_valid          = valid_r;
  assign out_success        = success_r;
  assign out_found_position = found_r;

endmodule

// ===== hdl/rect_occupancy_allocator_top.sv =====
// ----------------------------------------------------------------------------
// rect_occupancy_allocator_top
// First-fit rectangle allocator over a row-major occupancy bitmap, with an
// APB-style port for the grid size registers.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and its single result on out_found_position / out_success is flagged
// by out_valid high for exactly one cycle; there is no way to stall it, so
// sample it then. The bitmap is a one-bit-per-cell memory with a single
// port, and each visit to a cell inside the grid costs a memory access,
// which sets the latency. After reset busy stays high while the bitmap is
// swept clear, and a clear request keeps busy high for a full sweep. Test,
// put and free first split the position into row and column by repeated
// subtraction of grid_width; test and put then read and check each cell,
// put marks the cells once all are found free, and free clears its cells
// without reading them. Find tries one candidate position after another
// and reads cells until a taken cell rejects it. The result strobe rises
// in the same cycle that busy drops.
// ----------------------------------------------------------------------------
module rect_occupancy_allocator_top
  import roa_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [POS_W-1:0]  in_position,
  input  logic [DIM_W-1:0]  in_item_width,
  input  logic [DIM_W-1:0]  in_item_height,
  // result channel
  output logic              out_valid,
  output logic [POS_W-1:0]  out_found_position,
  output logic              out_success,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [DIM_W-1:0] grid_width_r;
  logic [DIM_W-1:0] grid_height_r;
  logic             cfg_wr;
  reg_idx_t         cfg_sel;
  cmd_t             cmd;
  sts_t             sts;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_GRID_WIDTH:  grid_width_r  <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= pwdata[DIM_W-1:0];
        default: begin
          grid_width_r <= grid_width_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_GRID_WIDTH:  prdata = 32'(grid_width_r);
      REG_GRID_HEIGHT: prdata = 32'(grid_height_r);
      default:         prdata = '0;
    endcase
  end

  roa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  roa_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .grid_width         (grid_width_r),
    .grid_height        (grid_height_r),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_item_width      (in_item_width),
    .in_item_height     (in_item_height),
    .out_found_position (out_found_position),
    .out_success        (out_success),
    .out_valid          (out_valid)
  );

endmodule
